### rtl/dcgate_pkg.sv
// ----------------------------------------------------------------------------
// dcgate_pkg
// Shared types and constants for the two-cell exact gate engine.
// ----------------------------------------------------------------------------
package dcgate_pkg;

  localparam int SCALE_W   = 6;
  localparam int OUT_COEFF = 64;
  localparam int IN_DATA_W = 8;
  localparam int OUT_DATA_W = 528;

  localparam logic [1:0] OP_RESET    = 2'd0;
  localparam logic [1:0] OP_HADAMARD = 2'd1;
  localparam logic [1:0] OP_ROTATE   = 2'd2;

endpackage

### rtl/dyadic_cyclotomic_two_cell_gate_engine.sv
// ----------------------------------------------------------------------------
// dyadic_cyclotomic_two_cell_gate_engine
// Two-cell exact state over Z[z,1/2], z^4 = -1, driven by reset, Hadamard
// and phase-rotate beats; one result beat with the full state per input beat.
// ----------------------------------------------------------------------------
// One input beat is taken at a time; s_axis_tready is low from acceptance
// until the result beat has been taken. A reset or unused op gives its
// result beat straight from idle. A phase rotate multiplies the lower cell
// by z^e, e the exponent, then strips factors of two. In a Hadamard step one
// shared shift/add unit aligns the cells one bit per cycle, forms sum and
// difference one coefficient per cycle, applies the 1/sqrt2 map one cell per
// cycle and strips factors of two one bit per cycle. Any overflow, or a scale
// above MAX_SCALE_POWER, sets the sticky overflow flag and keeps the state.
module dyadic_cyclotomic_two_cell_gate_engine
  import dcgate_pkg::*;
#(
  parameter int COEFF_WIDTH     = 64,
  parameter int MAX_SCALE_POWER = 61
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // op [1:0], phase_exponent [4:2]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // upper_c0..c3, upper_scale, lower_c0..c3, lower_scale, overflow, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int W = COEFF_WIDTH;

  typedef logic signed [W-1:0] coef_t;
  typedef logic signed [W:0]   wide_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ALIGN, ST_ADD, ST_STRIP1, ST_XFORM, ST_ROT, ST_STRIP2, ST_COMMIT
  } state_e;

  localparam coef_t CMIN = {1'b1, {(W-1){1'b0}}};

  state_e state_q;
  coef_t u_q [4];
  coef_t l_q [4];
  coef_t a_q [4];
  coef_t b_q [4];
  coef_t s_q [4];
  coef_t d_q [4];
  logic [SCALE_W-1:0] pu_q, pl_q, pa_q, pb_q, ps_q, pd_q;
  logic [2:0] cnt_q;
  logic err_q, ovf_q, out_valid_q;

  logic  sh_a_ov, sh_b_ov, add_ov, s_even, d_even, x_ov;
  wide_t sum_w, dif_w, t0, t1, t2, t3;
  coef_t x [4];

  function automatic logic wfit(wide_t v);
    return v[W] == v[W-1];
  endfunction

  always_comb begin
    sh_a_ov = 1'b0;
    sh_b_ov = 1'b0;
    for (int k = 0; k < 4; k++) begin
      sh_a_ov = sh_a_ov | (a_q[k][W-1] != a_q[k][W-2]);
      sh_b_ov = sh_b_ov | (b_q[k][W-1] != b_q[k][W-2]);
    end
    sum_w  = wide_t'(a_q[0]) + wide_t'(b_q[0]);
    dif_w  = wide_t'(a_q[0]) - wide_t'(b_q[0]);
    add_ov = !wfit(sum_w) || !wfit(dif_w) || (b_q[0] == CMIN);
    s_even = (ps_q != '0) && !(s_q[0][0] | s_q[1][0] | s_q[2][0] | s_q[3][0]);
    d_even = (pd_q != '0) && !(d_q[0][0] | d_q[1][0] | d_q[2][0] | d_q[3][0]);
    for (int k = 0; k < 4; k++) begin
      x[k] = cnt_q[0] ? d_q[k] : s_q[k];
    end
    t0 = wide_t'(x[1]) - wide_t'(x[3]);
    t1 = wide_t'(x[0]) + wide_t'(x[2]);
    t2 = wide_t'(x[1]) + wide_t'(x[3]);
    t3 = wide_t'(x[2]) - wide_t'(x[0]);
    x_ov = !wfit(t0) || (t0[W-1:0] == CMIN) || !wfit(t1) || !wfit(t2) || !wfit(t3) ||
           (x[0] == CMIN) || (x[1] == CMIN) || (x[2] == CMIN) || (x[3] == CMIN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      for (int k = 0; k < 4; k++) begin
        u_q[k] <= (k == 0) ? coef_t'(1) : '0;
        l_q[k] <= '0;
        a_q[k] <= '0;
        b_q[k] <= '0;
        s_q[k] <= '0;
        d_q[k] <= '0;
      end
      pu_q        <= '0;
      pl_q        <= '0;
      pa_q        <= '0;
      pb_q        <= '0;
      ps_q        <= '0;
      pd_q        <= '0;
      cnt_q       <= '0;
      err_q       <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            err_q <= 1'b0;
            unique case (s_axis_tdata[1:0])
              OP_RESET: begin
                for (int k = 0; k < 4; k++) begin
                  u_q[k] <= (k == 0) ? coef_t'(1) : '0;
                  l_q[k] <= '0;
                end
                pu_q        <= '0;
                pl_q        <= '0;
                out_valid_q <= 1'b1;
              end
              OP_HADAMARD: begin
                a_q     <= u_q;
                b_q     <= l_q;
                pa_q    <= pu_q;
                pb_q    <= pl_q;
                state_q <= ST_ALIGN;
              end
              OP_ROTATE: begin
                s_q     <= u_q;
                d_q     <= l_q;
                ps_q    <= pu_q;
                pd_q    <= pl_q;
                cnt_q   <= s_axis_tdata[4:2];
                state_q <= ST_ROT;
              end
              default: begin
                out_valid_q <= 1'b1;
              end
            endcase
          end
        end
        ST_ALIGN: begin
          priority if (pa_q < pb_q) begin
            for (int k = 0; k < 4; k++) a_q[k] <= a_q[k] <<< 1;
            pa_q  <= pa_q + 1'b1;
            err_q <= err_q | sh_a_ov;
          end else if (pb_q < pa_q) begin
            for (int k = 0; k < 4; k++) b_q[k] <= b_q[k] <<< 1;
            pb_q  <= pb_q + 1'b1;
            err_q <= err_q | sh_b_ov;
          end else begin
            ps_q    <= pa_q;
            pd_q    <= pa_q;
            cnt_q   <= '0;
            state_q <= ST_ADD;
          end
        end
        ST_ADD: begin
          for (int k = 0; k < 3; k++) begin
            a_q[k] <= a_q[k+1];
            b_q[k] <= b_q[k+1];
            s_q[k] <= s_q[k+1];
            d_q[k] <= d_q[k+1];
          end
          a_q[3] <= a_q[0];
          b_q[3] <= b_q[0];
          s_q[3] <= sum_w[W-1:0];
          d_q[3] <= dif_w[W-1:0];
          err_q  <= err_q | add_ov;
          cnt_q  <= cnt_q + 1'b1;
          if (cnt_q == 3'd3) begin
            state_q <= ST_STRIP1;
          end
        end
        ST_STRIP1, ST_STRIP2: begin
          if (s_even) begin
            for (int k = 0; k < 4; k++) s_q[k] <= s_q[k] >>> 1;
            ps_q <= ps_q - 1'b1;
          end
          if (d_even) begin
            for (int k = 0; k < 4; k++) d_q[k] <= d_q[k] >>> 1;
            pd_q <= pd_q - 1'b1;
          end
          if (!s_even && !d_even) begin
            cnt_q   <= '0;
            state_q <= (state_q == ST_STRIP1) ? ST_XFORM : ST_COMMIT;
          end
        end
        ST_XFORM: begin
          err_q <= err_q | x_ov;
          if (cnt_q[0]) begin
            d_q[0]  <= t0[W-1:0];
            d_q[1]  <= t1[W-1:0];
            d_q[2]  <= t2[W-1:0];
            d_q[3]  <= t3[W-1:0];
            pd_q    <= pd_q + 1'b1;
            state_q <= ST_STRIP2;
          end else begin
            s_q[0] <= t0[W-1:0];
            s_q[1] <= t1[W-1:0];
            s_q[2] <= t2[W-1:0];
            s_q[3] <= t3[W-1:0];
            ps_q   <= ps_q + 1'b1;
            cnt_q  <= 3'd1;
          end
        end
        ST_ROT: begin
          if (cnt_q == '0) begin
            state_q <= ST_STRIP2;
          end else begin
            d_q[0] <= -d_q[3];
            d_q[1] <= d_q[0];
            d_q[2] <= d_q[1];
            d_q[3] <= d_q[2];
            err_q  <= err_q | (d_q[3] == CMIN);
            cnt_q  <= cnt_q - 1'b1;
          end
        end
        ST_COMMIT: begin
          if (err_q || (ps_q > SCALE_W'(MAX_SCALE_POWER)) ||
              (pd_q > SCALE_W'(MAX_SCALE_POWER))) begin
            ovf_q <= 1'b1;
          end else begin
            u_q  <= s_q;
            l_q  <= d_q;
            pu_q <= ps_q;
            pl_q <= pd_q;
          end
          out_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE) && !out_valid_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, ovf_q, pl_q,
                          OUT_COEFF'(l_q[3]), OUT_COEFF'(l_q[2]),
                          OUT_COEFF'(l_q[1]), OUT_COEFF'(l_q[0]), pu_q,
                          OUT_COEFF'(u_q[3]), OUT_COEFF'(u_q[2]),
                          OUT_COEFF'(u_q[1]), OUT_COEFF'(u_q[0])};

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("ready while a result beat is pending");

  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |=> ovf_q)
    else $error("overflow flag cleared");

  a_scale_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pu_q <= SCALE_W'(MAX_SCALE_POWER)) && (pl_q <= SCALE_W'(MAX_SCALE_POWER)))
    else $error("stored scale above limit");

  a_commit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMMIT) |=> m_axis_tvalid)
    else $error("commit without result beat");

endmodule
